>>> rtl/core/lbps_pkg.sv
package lbps_pkg;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_FALL = 2'd3;

  localparam logic [1:0] DRV_OFF = 2'd0;
  localparam logic [1:0] DRV_DIM = 2'd1;
  localparam logic [1:0] DRV_ON  = 2'd2;

  localparam logic [6:0] DUTY_FULL = 7'd100;

  typedef struct packed {
    logic [3:0]  pattern_id;
    logic        pattern_valid;
    logic [15:0] low_time;
    logic [15:0] high_time;
    logic [7:0]  step_time;
    logic [6:0]  ramp_step;
  } lbps_tick_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] duty_level;
    logic [1:0] drive_held;
    logic [3:0] last_pattern;
    logic       last_valid;
  } lbps_state_t;

endpackage

>>> rtl/core/lbps_tick_if.sv
interface lbps_tick_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pattern_id;
  logic        pattern_valid;
  logic [15:0] low_time;
  logic [15:0] high_time;
  logic [7:0]  step_time;
  logic [6:0]  ramp_step;

  modport source (
    output valid, pattern_id, pattern_valid, low_time, high_time, step_time, ramp_step,
    input  ready
  );
  modport sink (
    input  valid, pattern_id, pattern_valid, low_time, high_time, step_time, ramp_step,
    output ready
  );
endinterface

>>> rtl/core/lbps_result_if.sv
interface lbps_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_mode;
  logic [6:0] duty_percent;
  logic [1:0] phase_now;

  modport source (
    output valid, drive_mode, duty_percent, phase_now,
    input  ready
  );
  modport sink (
    input  valid, drive_mode, duty_percent, phase_now,
    output ready
  );
endinterface

>>> rtl/core/led_breathing_pattern_sequencer.sv
// A tick passes through the input register and then the result register before its
// result is offered; a stalled result can hold it in between.
// Throughput: one tick per cycle while results are taken; the state update is a single
// add/compare pass per cycle. A stalled result holds the result register; the input
// register keeps taking ticks while it is empty or the result register can move.
// Reset (rst, synchronous): phase low, duty 0, drive off, wait count 0, no pattern held.
module led_breathing_pattern_sequencer import lbps_pkg::*; #(
  parameter int NUM_PATTERNS = 16,
  parameter int TIME_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  lbps_tick_if.sink   tick,
  lbps_result_if.source result
);

  logic                 in_valid;
  lbps_tick_t           in_item;
  logic                 advance;
  lbps_state_t          state;
  lbps_state_t          state_next;
  logic [TIME_BITS-1:0] wait_ticks;
  logic [TIME_BITS-1:0] wait_ticks_next;
  logic                 out_valid;
  logic [1:0]           drive_mode;
  logic [6:0]           duty_percent;
  logic [1:0]           phase_now;

  // the input register moves whenever the result register is free or being taken
  assign advance    = !out_valid || result.ready;
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
    if (tick.ready && tick.valid) begin
      in_item.pattern_id    <= tick.pattern_id;
      in_item.pattern_valid <= tick.pattern_valid;
      in_item.low_time      <= tick.low_time;
      in_item.high_time     <= tick.high_time;
      in_item.step_time     <= tick.step_time;
      in_item.ramp_step     <= tick.ramp_step;
    end
  end

  lbps_step #(
    .NUM_PATTERNS (NUM_PATTERNS),
    .TIME_BITS    (TIME_BITS)
  ) u_step (
    .item     (in_item),
    .cur      (state),
    .cur_wait (wait_ticks),
    .nxt      (state_next),
    .nxt_wait (wait_ticks_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_LOW;
      state.duty_level   <= 7'd0;
      state.drive_held   <= DRV_OFF;
      state.last_pattern <= 4'd0;
      state.last_valid   <= 1'b0;
      wait_ticks         <= '0;
      out_valid          <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        state      <= state_next;
        wait_ticks <= wait_ticks_next;
      end
    end
    if (advance && in_valid) begin
      drive_mode   <= state_next.drive_held;
      duty_percent <= state_next.duty_level;
      phase_now    <= state_next.phase;
    end
  end

  assign result.valid        = out_valid;
  assign result.drive_mode   = drive_mode;
  assign result.duty_percent = duty_percent;
  assign result.phase_now    = phase_now;

  // with no pattern held the sequencer must sit parked
  a_parked_when_invalid: assert property (@(posedge clk) disable iff (rst)
    !state.last_valid |-> (state.phase == PH_LOW && state.duty_level == 7'd0
                           && state.drive_held == DRV_OFF))
    else $error("sequencer not parked while no pattern is selected");

  a_duty_bounded: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.duty_percent <= DUTY_FULL && result.drive_mode <= DRV_ON))
    else $error("result duty or drive mode out of range");

  // state only moves on a tick that passes into the result register
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_valid) |=> ($stable(state) && $stable(wait_ticks)))
    else $error("sequencer state changed without a tick");

endmodule

>>> rtl/core/lbps_step.sv
module lbps_step import lbps_pkg::*; #(
  parameter int NUM_PATTERNS = 16,
  parameter int TIME_BITS    = 16
) (
  input  lbps_tick_t             item,
  input  lbps_state_t            cur,
  input  logic [TIME_BITS-1:0]   cur_wait,
  output lbps_state_t            nxt,
  output logic [TIME_BITS-1:0]   nxt_wait
);

  logic                 valid;
  logic                 restart;
  lbps_state_t          base;
  logic [TIME_BITS-1:0] base_wait;
  logic [7:0]           duty_sum;

  always_comb begin
    // an id beyond the table counts as no pattern
    valid   = item.pattern_valid && (32'(item.pattern_id) < NUM_PATTERNS);
    restart = (valid != cur.last_valid) || (valid && (item.pattern_id != cur.last_pattern));

    base      = cur;
    base_wait = cur_wait;
    if (restart) begin
      base.phase      = PH_LOW;
      base.duty_level = 7'd0;
      base.drive_held = DRV_OFF;
      base_wait       = '0;
    end
    base.last_valid   = valid;
    base.last_pattern = item.pattern_id;

    duty_sum = {1'b0, base.duty_level} + {1'b0, item.ramp_step};

    nxt      = base;
    nxt_wait = base_wait;
    if (valid) begin
      if (base_wait > TIME_BITS'(1)) begin
        nxt_wait = base_wait - TIME_BITS'(1);
      end else begin
        unique case (base.phase)
          PH_LOW: begin
            nxt.drive_held = DRV_OFF;
            nxt.phase      = PH_RISE;
            nxt_wait       = TIME_BITS'(item.low_time);
          end
          PH_RISE: begin
            // saturate at full duty
            if (duty_sum >= {1'b0, DUTY_FULL}) begin
              nxt.duty_level = DUTY_FULL;
              nxt.phase      = PH_HIGH;
            end else begin
              nxt.duty_level = duty_sum[6:0];
            end
            nxt.drive_held = DRV_DIM;
            nxt_wait       = TIME_BITS'(item.step_time);
          end
          PH_HIGH: begin
            nxt.drive_held = DRV_ON;
            nxt.phase      = PH_FALL;
            nxt_wait       = TIME_BITS'(item.high_time);
          end
          default: begin
            if (base.duty_level <= item.ramp_step) begin
              nxt.duty_level = 7'd0;
              nxt.phase      = PH_LOW;
            end else begin
              nxt.duty_level = base.duty_level - item.ramp_step;
            end
            nxt.drive_held = DRV_DIM;
            nxt_wait       = TIME_BITS'(item.step_time);
          end
        endcase
      end
    end
  end

endmodule
